// File: src/ech_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ech_pkg
// Shared types, constants and constant tables for the exponential chirp block.
// ----------------------------------------------------------------------------
package ech_pkg;

  localparam int TIME_BITS_DEF  = 28;
  localparam int PHASE_BITS_DEF = 32;

  localparam int EXP_TERMS  = 12;
  localparam int SINE_TERMS = 7;

  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam logic [14:0] LN2_RECIP   = 15'd23637;      // floor(2^44 / LN2_Q30)
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [29:0] TURN_SCALE  = 30'd716770142;
  localparam logic [14:0] GAIN_Q20    = 15'd19608;
  localparam logic [27:0] US_PER_S    = 28'd1000000;

  localparam logic [7:0]  PERIOD_RST  = 8'd30;
  localparam logic [14:0] AMP_RST     = 15'd16384;
  localparam logic [15:0] START_RST   = 16'd768;
  localparam logic [15:0] END_RST     = 16'd13312;

  typedef enum logic [1:0] {
    CFG_PERIOD,
    CFG_AMPLITUDE,
    CFG_START_RATE,
    CFG_END_RATE
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DISARM,
    OP_OVER,
    OP_ADV,
    OP_DIV_STEP,
    OP_RED_MUL,
    OP_RED_SET,
    OP_EXP_INIT,
    OP_MUL_TERM_R,
    OP_MUL_RECIP,
    OP_TAYLOR_FIX,
    OP_GAIN_MUL,
    OP_GAIN_SCALE,
    OP_RATE_MUL,
    OP_RATE_SET,
    OP_Q_MUL,
    OP_Q_SET,
    OP_D_HI,
    OP_D_LO,
    OP_PHASE,
    OP_X_MUL,
    OP_X_SET,
    OP_SIN_M1,
    OP_SIN_M2,
    OP_SINE_FIX,
    OP_AMP_MUL,
    OP_FIN,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV1,
    ST_RED0,
    ST_RED1,
    ST_EXP0,
    ST_T_MUL,
    ST_T_REC,
    ST_T_FIX,
    ST_K0,
    ST_K1,
    ST_R0,
    ST_R1,
    ST_Q0,
    ST_Q1,
    ST_D0,
    ST_D1,
    ST_PH,
    ST_X0,
    ST_X1,
    ST_S_M1,
    ST_S_M2,
    ST_S_REC,
    ST_S_FIX,
    ST_AMP,
    ST_FIN,
    ST_EMIT
  } ctl_state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [7:0] divisor;
    logic       sub;
  } dp_cmd_t;

  typedef struct packed {
    logic armed;
    logic sweep_on;
    logic out_free;
  } dp_sts_t;

  // floor((2^32 - 1) / d) for the small divisors of both series
  function automatic logic [31:0] recip_q32(input logic [7:0] d);
    logic [31:0] m;
    case (d)
      8'd1:    m = 32'd4294967295;
      8'd2:    m = 32'd2147483647;
      8'd3:    m = 32'd1431655765;
      8'd4:    m = 32'd1073741823;
      8'd5:    m = 32'd858993459;
      8'd6:    m = 32'd715827882;
      8'd7:    m = 32'd613566756;
      8'd8:    m = 32'd536870911;
      8'd9:    m = 32'd477218588;
      8'd10:   m = 32'd429496729;
      8'd11:   m = 32'd390451572;
      8'd12:   m = 32'd357913941;
      8'd20:   m = 32'd214748364;
      8'd42:   m = 32'd102261126;
      8'd72:   m = 32'd59652323;
      8'd110:  m = 32'd39045157;
      8'd156:  m = 32'd27531841;
      8'd210:  m = 32'd20452225;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

  // (2k)(2k+1) for sine term k
  function automatic logic [7:0] sine_div(input logic [3:0] k);
    logic [7:0] d;
    case (k)
      4'd1:    d = 8'd6;
      4'd2:    d = 8'd20;
      4'd3:    d = 8'd42;
      4'd4:    d = 8'd72;
      4'd5:    d = 8'd110;
      4'd6:    d = 8'd156;
      4'd7:    d = 8'd210;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

endpackage

// File: src/ech_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ech_ctrl
// Sequencer: steps the datapath through division, exp series, rate, phase
// and sine series for one tick; disarmed or finished-sweep ticks go to emit.
// ----------------------------------------------------------------------------
module ech_ctrl
  import ech_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam int QW   = TIME_BITS - 1;
  localparam int CNTW = $clog2(QW);

  ctl_state_t      state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [3:0]      k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (!sts.armed || !sts.sweep_on) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_DIV1;
          cnt_nxt   = CNTW'(QW - 1);
        end
      end
      ST_DIV1: begin
        if (cnt_r == '0) state_nxt = ST_RED0;
        else cnt_nxt = cnt_r - 1'b1;
      end
      ST_RED0: state_nxt = ST_RED1;
      ST_RED1: state_nxt = ST_EXP0;
      ST_EXP0: begin
        state_nxt = ST_T_MUL;
        k_nxt     = 4'd1;
      end
      ST_T_MUL: state_nxt = ST_T_REC;
      ST_T_REC: state_nxt = ST_T_FIX;
      ST_T_FIX: begin
        if (k_r == 4'(EXP_TERMS)) begin
          state_nxt = ST_K0;
        end else begin
          state_nxt = ST_T_MUL;
          k_nxt     = k_r + 4'd1;
        end
      end
      ST_K0: state_nxt = ST_K1;
      ST_K1: state_nxt = ST_R0;
      ST_R0: state_nxt = ST_R1;
      ST_R1: state_nxt = ST_Q0;
      ST_Q0: state_nxt = ST_Q1;
      ST_Q1: state_nxt = ST_D0;
      ST_D0: state_nxt = ST_D1;
      ST_D1: state_nxt = ST_PH;
      ST_PH: state_nxt = ST_X0;
      ST_X0: state_nxt = ST_X1;
      ST_X1: begin
        state_nxt = ST_S_M1;
        k_nxt     = 4'd1;
      end
      ST_S_M1:  state_nxt = ST_S_M2;
      ST_S_M2:  state_nxt = ST_S_REC;
      ST_S_REC: state_nxt = ST_S_FIX;
      ST_S_FIX: begin
        if (k_r == 4'(SINE_TERMS)) begin
          state_nxt = ST_AMP;
        end else begin
          state_nxt = ST_S_M1;
          k_nxt     = k_r + 4'd1;
        end
      end
      ST_AMP: state_nxt = ST_FIN;
      ST_FIN: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.op      = OP_NONE;
    cmd.divisor = k_r[3:0] == 4'd0 ? 8'd1 : 8'(k_r);
    cmd.sub     = k_r[0];
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = OP_LOAD;
      end
      ST_EVAL: begin
        if (!sts.armed) cmd.op = OP_DISARM;
        else if (!sts.sweep_on) cmd.op = OP_OVER;
        else cmd.op = OP_ADV;
      end
      ST_DIV1:  cmd.op = OP_DIV_STEP;
      ST_RED0:  cmd.op = OP_RED_MUL;
      ST_RED1:  cmd.op = OP_RED_SET;
      ST_EXP0:  cmd.op = OP_EXP_INIT;
      ST_T_MUL: cmd.op = OP_MUL_TERM_R;
      ST_T_REC: cmd.op = OP_MUL_RECIP;
      ST_T_FIX: cmd.op = OP_TAYLOR_FIX;
      ST_K0:    cmd.op = OP_GAIN_MUL;
      ST_K1:    cmd.op = OP_GAIN_SCALE;
      ST_R0:    cmd.op = OP_RATE_MUL;
      ST_R1:    cmd.op = OP_RATE_SET;
      ST_Q0:    cmd.op = OP_Q_MUL;
      ST_Q1:    cmd.op = OP_Q_SET;
      ST_D0:    cmd.op = OP_D_HI;
      ST_D1:    cmd.op = OP_D_LO;
      ST_PH:    cmd.op = OP_PHASE;
      ST_X0:    cmd.op = OP_X_MUL;
      ST_X1:    cmd.op = OP_X_SET;
      ST_S_M1:  cmd.op = OP_SIN_M1;
      ST_S_M2:  cmd.op = OP_SIN_M2;
      ST_S_REC: begin
        cmd.op      = OP_MUL_RECIP;
        cmd.divisor = sine_div(k_r);
      end
      ST_S_FIX: begin
        cmd.op      = OP_SINE_FIX;
        cmd.divisor = sine_div(k_r);
      end
      ST_AMP:   cmd.op = OP_AMP_MUL;
      ST_FIN:   cmd.op = OP_FIN;
      ST_EMIT: begin
        if (sts.out_free) cmd.op = OP_EMIT;
      end
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

// File: src/ech_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ech_datapath
// Config registers, sweep state, shared 32x32 multiplier, radix-2 divider,
// series accumulators and the output register.
// ----------------------------------------------------------------------------
module ech_datapath
  import ech_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic [19:0] in_step,
  input  logic        in_armed,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_data,
  output logic        out_sweep
);

  localparam int QW  = TIME_BITS - 1;   // quotient bits of elapsed/period
  localparam int RW  = 31;
  localparam int DW  = 57;
  localparam int SHR = 40 - PHASE_BITS;
  localparam int CW  = (TIME_BITS > 28) ? TIME_BITS : 28;
  localparam logic [DW-1:0] RND = (DW'(1) << SHR) >> 1;

  logic [7:0]  period_r;
  logic [14:0] amp_r;
  logic [15:0] start_r, end_r;

  logic [TIME_BITS-1:0]  elapsed_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic [15:0]           held_r;

  logic [19:0]   step_r;
  logic          armed_r;
  logic [29:0]   div_r;
  logic [RW-1:0] rem_r;
  logic [QW-1:0] lo_r;
  logic [4:0]    iq_r;
  logic [3:0]    i_r;
  logic [31:0]   term_r, sum_r, p_r, s_r;
  logic [63:0]   mul_r;
  logic [23:0]   k_r;
  logic          rate_neg_r;
  logic [24:0]   rate_mag_r;
  logic [21:0]   l_r;
  logic [DW-1:0] dacc_r;
  logic [1:0]    quad_r;
  logic [30:0]   x_r;
  logic [15:0]   res_r;
  logic          res_sweep_r;
  logic          out_valid_r;
  logic [15:0]   out_data_r;
  logic          out_sweep_r;

  // elapsed time update and division operands
  logic [27:0]            period_us;
  logic                   sweep_on;
  logic [TIME_BITS:0]     el_sum;
  logic [TIME_BITS-1:0]   el_sat;
  logic [TIME_BITS+17:0]  n1;

  assign period_us = 28'(period_r) * US_PER_S;
  assign sweep_on  = CW'(elapsed_r) < CW'(period_us);
  assign el_sum    = {1'b0, elapsed_r} + (TIME_BITS+1)'(step_r);
  assign el_sat    = el_sum[TIME_BITS] ? '1 : el_sum[TIME_BITS-1:0];
  assign n1        = {el_sat, 18'd0};

  // restoring divider step
  logic [RW-1:0] rem_sh;
  logic          div_ge;
  assign rem_sh = {rem_r[RW-2:0], lo_r[QW-1]};
  assign div_ge = rem_sh >= {1'b0, div_r};

  // ln2 reduction: the ratio stays below 2^20 while inside the sweep, so a
  // reciprocal estimate is at most one low and one compare fixes it
  logic [4:0]  i_est;
  logic [33:0] a30;
  logic [34:0] i_ln2;
  logic [34:0] r0;
  logic        red_ge;
  logic [4:0]  i_fix;
  assign i_est  = mul_r[34:30];
  assign a30    = {lo_r[19:0], 14'd0};
  assign i_ln2  = 35'(i_est) * 35'(LN2_Q30);
  assign r0     = 35'(a30) - i_ln2;
  assign red_ge = rem_r >= RW'(LN2_Q30);
  assign i_fix  = iq_r + 5'(red_ge);

  // small-constant division: reciprocal estimate, then up to two corrections
  logic [31:0] q0, qd, frem, qt, dv32;
  assign dv32 = 32'(cmd.divisor);
  assign q0   = mul_r[63:32];
  assign qd   = 32'(q0 * dv32);
  assign frem = p_r - qd;
  assign qt   = q0 + 32'(frem >= dv32) + 32'(frem >= {dv32[30:0], 1'b0});

  logic        end_ge;
  logic [15:0] diff_mag;
  assign end_ge   = end_r >= start_r;
  assign diff_mag = end_ge ? end_r - start_r : start_r - end_r;

  logic [57:0] g58;
  logic [58:0] kt;
  assign g58 = 58'(mul_r[45:0]) << i_r;
  assign kt  = 59'(g58) + (59'(1) << 33);

  logic [40:0] rm_t;
  logic [24:0] rm;
  assign rm_t = 41'(mul_r[39:0]) + 41'd32768;
  assign rm   = rm_t[40:16];

  logic [52:0] dlo_t;
  assign dlo_t = 53'(mul_r[51:0]) + (53'(1) << 19);

  logic [DW-1:0]         d_rnd;
  logic [PHASE_BITS-1:0] d_pb;
  assign d_rnd = dacc_r + RND;
  assign d_pb  = PHASE_BITS'(d_rnd >> SHR);

  logic [31:0] p32;
  generate
    if (PHASE_BITS >= 32) begin : g_p_hi
      assign p32 = phase_r[PHASE_BITS-1 -: 32];
    end else begin : g_p_lo
      assign p32 = {phase_r, {(32-PHASE_BITS){1'b0}}};
    end
  endgenerate

  logic [30:0] f_mir;
  assign f_mir = p32[30] ? 31'(ONE_Q30) - {1'b0, p32[29:0]} : {1'b0, p32[29:0]};

  logic [30:0] s_clamp;
  assign s_clamp = (s_r > ONE_Q30) ? 31'(ONE_Q30) : s_r[30:0];

  logic [46:0] mag_t;
  logic [15:0] mag;
  assign mag_t = 47'(mul_r[45:0]) + (47'(1) << 29);
  assign mag   = mag_t[45:30];

  // shared multiplier operand select
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        mul_en;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_RED_MUL: begin
        mul_a = 32'(lo_r[19:0]);
        mul_b = 32'(LN2_RECIP);
      end
      OP_MUL_TERM_R: begin
        mul_a = term_r;
        mul_b = 32'(rem_r[29:0]);
      end
      OP_MUL_RECIP: begin
        mul_a = mul_r[61:30];
        mul_b = recip_q32(cmd.divisor);
      end
      OP_GAIN_MUL: begin
        // (sum << i) - 1.0 == (sum - (1.0 >> i)) << i, exact for i <= 12
        mul_a = sum_r - (ONE_Q30 >> i_r);
        mul_b = 32'(GAIN_Q20);
      end
      OP_RATE_MUL: begin
        mul_a = 32'(k_r);
        mul_b = 32'(diff_mag);
      end
      OP_Q_MUL: begin
        mul_a = 32'(rate_mag_r);
        mul_b = 32'(step_r);
      end
      OP_Q_SET: begin
        mul_a = 32'(mul_r[44:22]);
        mul_b = 32'(TURN_SCALE);
      end
      OP_D_HI: begin
        mul_a = 32'(l_r);
        mul_b = 32'(TURN_SCALE);
      end
      OP_X_MUL: begin
        mul_a = 32'(f_mir);
        mul_b = 32'(HALF_PI_Q30);
      end
      OP_SIN_M1: begin
        mul_a = term_r;
        mul_b = 32'(x_r);
      end
      OP_SIN_M2: begin
        mul_a = mul_r[61:30];
        mul_b = 32'(x_r);
      end
      OP_AMP_MUL: begin
        mul_a = 32'(amp_r);
        mul_b = 32'(s_clamp);
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (mul_en) mul_r <= mul_p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RST;
      amp_r       <= AMP_RST;
      start_r     <= START_RST;
      end_r       <= END_RST;
      elapsed_r   <= '0;
      phase_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_PERIOD:     period_r <= cfg_wdata[7:0];
          CFG_AMPLITUDE:  amp_r    <= cfg_wdata[14:0];
          CFG_START_RATE: start_r  <= cfg_wdata;
          CFG_END_RATE:   end_r    <= cfg_wdata;
          default: ;
        endcase
      end

      if (cmd.op == OP_EMIT) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      case (cmd.op)
        OP_LOAD: begin
          step_r  <= in_step;
          armed_r <= in_armed;
        end
        OP_DISARM: begin
          elapsed_r   <= '0;
          res_r       <= held_r;
          res_sweep_r <= 1'b0;
        end
        OP_OVER: begin
          elapsed_r   <= el_sat;
          held_r      <= '0;
          res_r       <= '0;
          res_sweep_r <= 1'b0;
        end
        OP_ADV: begin
          elapsed_r <= el_sat;
          rem_r     <= RW'(n1[TIME_BITS+17:QW]);
          lo_r      <= n1[QW-1:0];
          div_r     <= 30'(period_us);
        end
        OP_DIV_STEP: begin
          rem_r <= div_ge ? rem_sh - {1'b0, div_r} : rem_sh;
          lo_r  <= {lo_r[QW-2:0], div_ge};
        end
        OP_RED_SET: begin
          rem_r <= r0[RW-1:0];
          iq_r  <= i_est;
        end
        OP_EXP_INIT: begin
          i_r    <= (i_fix > 5'd12) ? 4'd12 : i_fix[3:0];
          rem_r  <= red_ge ? rem_r - RW'(LN2_Q30) : rem_r;
          term_r <= ONE_Q30;
          sum_r  <= ONE_Q30;
        end
        OP_MUL_RECIP: p_r <= mul_r[61:30];
        OP_TAYLOR_FIX: begin
          term_r <= qt;
          sum_r  <= sum_r + qt;
        end
        OP_GAIN_SCALE: k_r <= kt[57:34];
        OP_RATE_SET: begin
          if (end_ge) begin
            rate_neg_r <= 1'b0;
            rate_mag_r <= 25'(start_r) + rm;
          end else if (rm > 25'(start_r)) begin
            rate_neg_r <= 1'b1;
            rate_mag_r <= rm - 25'(start_r);
          end else begin
            rate_neg_r <= 1'b0;
            rate_mag_r <= 25'(start_r) - rm;
          end
        end
        OP_Q_SET: l_r    <= mul_r[21:0];
        OP_D_HI:  dacc_r <= DW'({mul_r[52:0], 2'b00});
        OP_D_LO:  dacc_r <= dacc_r + DW'(dlo_t[52:20]);
        OP_PHASE: phase_r <= rate_neg_r ? phase_r - d_pb : phase_r + d_pb;
        OP_X_MUL: quad_r <= p32[31:30];
        OP_X_SET: begin
          x_r    <= mul_r[60:30];
          term_r <= 32'(mul_r[60:30]);
          s_r    <= 32'(mul_r[60:30]);
        end
        OP_SINE_FIX: begin
          term_r <= qt;
          s_r    <= cmd.sub ? s_r - qt : s_r + qt;
        end
        OP_FIN: begin
          res_r       <= quad_r[1] ? (~mag + 16'd1) : mag;
          held_r      <= quad_r[1] ? (~mag + 16'd1) : mag;
          res_sweep_r <= 1'b1;
        end
        OP_EMIT: begin
          out_data_r  <= res_r;
          out_sweep_r <= res_sweep_r;
        end
        default: ;
      endcase
    end
  end

  assign sts.armed    = armed_r;
  assign sts.sweep_on = sweep_on;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_data   = out_data_r;
  assign out_sweep  = out_sweep_r;

endmodule

// File: src/exponential_chirp_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exponential_chirp_generator
// Exponential frequency-sweep excitation source, one sample per tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per control tick. in_tdata[19:0] = step in us,
//           in_tuser = armed.
//   out_* : one transaction per tick. out_tdata = excitation (signed Q2.14),
//           out_tuser = 1 when the tick fell inside the sweep period.
//   cfg_* : register writes (period, amplitude, start rate, end rate): the
//           user must write only while no tick is in flight; not enforced.
// Sequence: an armed tick inside the sweep runs from acceptance to
//   out_tvalid through the bit-serial elapsed/period divider, then the
//   12-term exp and 7-term sine series on one shared 32x32 multiplier.
//   The next tick is taken in the cycle after the result is loaded into
//   the output register. Disarmed or finished-sweep ticks skip the divider
//   and both series. One tick at a time.
// Reset: registers return to their defaults; elapsed time, phase and the
//   held sample clear.
// Stall: the result sits in the output register; the next tick is accepted
//   and processed, and its result waits until the held one is taken.
// ----------------------------------------------------------------------------
module exponential_chirp_generator
  import ech_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [19:0] step_us, [23:20] zero
  input  logic        in_tuser,   // [0] armed
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] excitation
  output logic        out_tuser   // [0] sweeping
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ech_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ech_datapath #(
    .TIME_BITS  (TIME_BITS),
    .PHASE_BITS (PHASE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_step    (in_tdata[19:0]),
    .in_armed   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_tdata),
    .out_sweep  (out_tuser)
  );

endmodule
